FILE: rtl/skc_pkg.sv
// shared types and constants of the sorted set-associative key cache
package skc_pkg;

	localparam int SKC_NUM_SETS     = 4;
	localparam int SKC_SET_W        = 2;
	localparam int SKC_SET_CAPACITY = 16;
	localparam int SKC_KEY_W        = 32;
	localparam int SKC_VAL_W        = 32;

	// request codes
	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_ERASE  = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic                 cmp;
		logic                 upd;
		func_t                func;
		logic [SKC_SET_W-1:0] set;
		logic [SKC_KEY_W-1:0] key;
		logic [SKC_VAL_W-1:0] value;
		logic                 found;
		logic                 full;
	} skc_ctrl_t;

endpackage

FILE: rtl/skc_cell.sv
// one slot of every set: compare flags and shift towards either neighbour
module skc_cell
	import skc_pkg::*;
#(
	parameter int SET_CAPACITY = SKC_SET_CAPACITY,
	parameter int IDX          = 0,
	localparam int CNT_W       = $clog2(SET_CAPACITY)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  skc_ctrl_t            ctrl,
	input  logic [CNT_W-1:0]     cnt,
	input  logic                 left_pos,
	input  logic [SKC_KEY_W-1:0] left_key,
	input  logic [SKC_VAL_W-1:0] left_val,
	input  logic                 right_valid,
	input  logic [SKC_KEY_W-1:0] right_key,
	input  logic [SKC_VAL_W-1:0] right_val,
	output logic                 pos,
	output logic                 eq,
	output logic                 valid,
	output logic [SKC_KEY_W-1:0] key_o,
	output logic [SKC_VAL_W-1:0] val_o
);

	logic [SKC_KEY_W-1:0] keys_q [SKC_NUM_SETS];
	logic [SKC_VAL_W-1:0] vals_q [SKC_NUM_SETS];
	logic valid_q, pos_q, eq_q, last_q;
	logic in_range, at_cnt, is_last;
	logic take_new, take_left, take_right, set_val;

	assign key_o = keys_q[ctrl.set];
	assign val_o = vals_q[ctrl.set];
	assign pos   = pos_q;
	assign eq    = eq_q;
	assign valid = valid_q;

	// slot position against the set fill count
	assign in_range = IDX < int'(cnt);
	assign at_cnt   = IDX == int'(cnt);
	assign is_last  = (IDX + 1) == int'(cnt);

	// compare flags, taken while the item is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 1'b0;
			eq_q    <= 1'b0;
			last_q  <= 1'b0;
		end else if (ctrl.cmp) begin
			valid_q <= in_range;
			eq_q    <= in_range && (key_o == ctrl.key);
			pos_q   <= in_range ? (key_o >= ctrl.key) : at_cnt;
			last_q  <= is_last;
		end
	end

	// slot update for the current item
	always_comb begin
		take_new   = 1'b0;
		take_left  = 1'b0;
		take_right = 1'b0;
		set_val    = 1'b0;
		case (ctrl.func)
			FUNC_INSERT: begin
				if (ctrl.found) begin
					set_val = eq_q;
				end else if (ctrl.full) begin
					take_new = valid_q && ((pos_q && !left_pos) || (last_q && !pos_q));
				end else begin
					take_new  = pos_q && !left_pos;
					take_left = pos_q && left_pos;
				end
			end
			FUNC_ERASE: begin
				take_right = ctrl.found && pos_q && right_valid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			if (take_new) begin
				keys_q[ctrl.set] <= ctrl.key;
				vals_q[ctrl.set] <= ctrl.value;
			end else if (take_left) begin
				keys_q[ctrl.set] <= left_key;
				vals_q[ctrl.set] <= left_val;
			end else if (take_right) begin
				keys_q[ctrl.set] <= right_key;
				vals_q[ctrl.set] <= right_val;
			end else if (set_val) begin
				vals_q[ctrl.set] <= ctrl.value;
			end
		end
	end

endmodule

FILE: rtl/sorted_set_assoc_key_cache_top.sv
// top level: request sequencer, set fill counts and the chain of slot cells
//
//  channel | direction | handshake           | fields
//  request | in        | in_valid, in_ready  | func, key, value
//  result  | out       | out_valid, out_ready| hit, value_out
//
// an item has a compare step and an update step: the accepting edge registers
// the compare flags of every cell against the key; the update step shifts or
// writes the cells of the selected set and loads the result register. a held
// result stalls the update; the next item is taken once it is done. reset clears
// the fill counts and control state; slot contents stay undefined until written.
module sorted_set_assoc_key_cache_top
	import skc_pkg::*;
#(
	parameter int SET_CAPACITY = SKC_SET_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [SKC_KEY_W-1:0] key,
	input  logic [SKC_VAL_W-1:0] value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [SKC_VAL_W-1:0] value_out
);

	localparam int CNT_W = $clog2(SET_CAPACITY);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} state_t;

	state_t               state_q;
	func_t                func_q;
	logic [SKC_KEY_W-1:0] key_q;
	logic [SKC_VAL_W-1:0] value_q;
	logic [CNT_W-1:0]     cnt_q [SKC_NUM_SETS];
	logic                 out_valid_q, hit_q;
	logic [SKC_VAL_W-1:0] value_out_q;

	skc_ctrl_t            ctrl;
	logic [CNT_W-1:0]     cnt_sel;
	logic                 accept, can_out, do_upd;
	logic                 found;
	logic [SKC_VAL_W-1:0] hit_val;

	logic                 c_pos   [SET_CAPACITY];
	logic                 c_eq    [SET_CAPACITY];
	logic                 c_valid [SET_CAPACITY];
	logic [SKC_KEY_W-1:0] c_key   [SET_CAPACITY];
	logic [SKC_VAL_W-1:0] c_val   [SET_CAPACITY];

	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign can_out   = !out_valid_q || out_ready;
	assign do_upd    = (state_q == ST_UPD) && can_out;
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign value_out = value_out_q;

	// broadcast: key and set from the ports during compare, the held item during update
	always_comb begin
		ctrl.cmp   = accept;
		ctrl.upd   = do_upd;
		ctrl.func  = func_q;
		ctrl.key   = key_q;
		ctrl.value = value_q;
		ctrl.set   = key_q[SKC_SET_W-1:0];
		if (state_q == ST_IDLE) begin
			ctrl.key = key;
			ctrl.set = key[SKC_SET_W-1:0];
		end
		cnt_sel    = cnt_q[ctrl.set];
		ctrl.found = found;
		ctrl.full  = int'(cnt_sel) == SET_CAPACITY - 1;
	end

	// hit flag and stored value gathered from the cells
	always_comb begin
		found   = 1'b0;
		hit_val = '0;
		for (int i = 0; i < SET_CAPACITY; i++) begin
			found   = found | c_eq[i];
			hit_val = hit_val | (c_eq[i] ? c_val[i] : '0);
		end
	end

	// chain of slot cells
	for (genvar g = 0; g < SET_CAPACITY; g++) begin : g_cell
		logic                 lp, rv;
		logic [SKC_KEY_W-1:0] lk, rk;
		logic [SKC_VAL_W-1:0] lv, rvl;
		if (g == 0) begin : g_first
			assign lp = 1'b0;
			assign lk = '0;
			assign lv = '0;
		end else begin : g_mid
			assign lp = c_pos[g-1];
			assign lk = c_key[g-1];
			assign lv = c_val[g-1];
		end
		if (g == SET_CAPACITY - 1) begin : g_last
			assign rv  = 1'b0;
			assign rk  = '0;
			assign rvl = '0;
		end else begin : g_inner
			assign rv  = c_valid[g+1];
			assign rk  = c_key[g+1];
			assign rvl = c_val[g+1];
		end
		skc_cell #(
			.SET_CAPACITY(SET_CAPACITY),
			.IDX         (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.cnt        (cnt_sel),
			.left_pos   (lp),
			.left_key   (lk),
			.left_val   (lv),
			.right_valid(rv),
			.right_key  (rk),
			.right_val  (rvl),
			.pos        (c_pos[g]),
			.eq         (c_eq[g]),
			.valid      (c_valid[g]),
			.key_o      (c_key[g]),
			.val_o      (c_val[g])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (can_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held item
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(func);
			key_q   <= key;
			value_q <= value;
		end
	end

	// set fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SKC_NUM_SETS; s++) cnt_q[s] <= '0;
		end else if (do_upd) begin
			case (func_q)
				FUNC_CLEAR: begin
					for (int s = 0; s < SKC_NUM_SETS; s++) cnt_q[s] <= '0;
				end
				FUNC_INSERT: begin
					if (!found && !ctrl.full) cnt_q[ctrl.set] <= cnt_sel + 1'b1;
				end
				FUNC_ERASE: begin
					if (found) cnt_q[ctrl.set] <= cnt_sel - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_upd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd) begin
			hit_q       <= found && (func_q != FUNC_CLEAR);
			value_out_q <= (found && func_q == FUNC_LOOKUP) ? hit_val : '0;
		end
	end

endmodule

FILE: rtl/skc_checker.sv
// port checker for the key cache top level, bound to it below
module skc_checker
	import skc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic [SKC_VAL_W-1:0] value_out
);

	// a held result keeps its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(value_out))
		else $error("result changed while stalled");

	// one item at a time: busy in the cycle after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// a non-zero value only comes with a hit
	a_val_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (value_out != '0) |-> hit)
		else $error("value without hit");

	// a result appears only after the item's update cycle
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a busy cycle");

endmodule

bind sorted_set_assoc_key_cache_top skc_checker u_skc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.hit      (hit),
	.value_out(value_out)
);
